// ----- design/rrts_pkg.sv -----
// ============================================================================
// rrts_pkg: shared types and constants of the round-robin task scheduler
// Item and result layouts, controller command and status groups, and the
// fixed field widths that the datapath and the top level rely on.
// ============================================================================
package rrts_pkg;

  // Fixed field widths.
  localparam int ID_W    = 4;
  localparam int EXEC_W  = 16;
  localparam int QUANT_W = 8;
  localparam int OUT_T_W = 16;

  // Defaults of the top-level parameters.
  localparam int MAX_TASKS_DEF = 16;
  localparam int TIME_BITS_DEF = 16;

  // Quantum after reset.
  localparam logic [QUANT_W-1:0] QUANTUM_RESET = 8'd2;

  // Item modes.
  localparam logic MODE_ADMIT = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [ID_W-1:0]   task_id;
    logic [EXEC_W-1:0] compute_time;
  } in_t;

  typedef struct packed {
    logic               elected_valid;
    logic [ID_W-1:0]    elected_task;
    logic               finished_valid;
    logic [ID_W-1:0]    finished_task;
    logic [OUT_T_W-1:0] response_time;
    logic [OUT_T_W-1:0] waiting_time;
    logic               admit_error;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic admit;      // admit the item on the input port
    logic tick_clear; // clear the result register at the start of a tick
    logic task_read;  // read the per-task entry of the task at the queue head
    logic finish;     // retire the examined task and pop the queue
    logic rotate;     // move the examined task to the tail with a fresh quantum
    logic wait_calc;  // work out response and waiting time of the retired task
    logic elect;      // charge one tick to the examined task and report it
    logic tick_adv;   // advance the tick counter
    logic done;       // the result register holds a complete result
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_zero;    // run queue is empty
    logic finish_due;    // examined task has run its whole compute length
    logic quantum_spent; // examined task has no quantum left
  } ctl_status_t;

endpackage

// ----- design/round_robin_task_scheduler_unit.sv -----
// ============================================================================
// round_robin_task_scheduler_unit: round-robin scheduler with a time quantum
// Keeps a run queue of task ids; admit items append tasks, tick items retire,
// rotate and elect the head task and report the outcome.
// ============================================================================
// The block takes one item at a time: an item is accepted when start is high
// and busy is low, and its single result appears on rsp for exactly one cycle,
// marked by rsp_valid, in the cycle after the item's last step. The receiver
// cannot stall the result, so it must take rsp whenever rsp_valid is high.
// An admit, and a tick on an empty queue, end in the cycle they are accepted.
// A tick whose head task keeps running passes S_TRD and S_EXAM; one that
// rotates the head to the tail goes on through S_QRD, S_TRD and S_ELECT, and
// one that retires the head passes S_WAIT first and ends there when the
// queue empties. The run queue memory and the per-task stores have
// registered reads. The quantum register may be written over the cfg
// channel only while the block is idle; it is always ready.
module round_robin_task_scheduler_unit #(
  parameter int MAX_TASKS = rrts_pkg::MAX_TASKS_DEF,
  parameter int TIME_BITS = rrts_pkg::TIME_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  rrts_pkg::in_t                req,
  output logic                         rsp_valid,
  output rrts_pkg::out_t               rsp,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [rrts_pkg::QUANT_W-1:0] cfg_data
);

  rrts_pkg::ctl_cmd_t    cmd;
  rrts_pkg::ctl_status_t status;

  // The quantum register can take a write in any cycle.
  assign cfg_ready = 1'b1;

  // Controller: decides per cycle which datapath step runs.
  rrts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .mode      (req.mode),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .rsp_valid (rsp_valid)
  );

  // Datapath: queue, per-task stores, counters and the result register.
  rrts_datapath #(
    .MAX_TASKS (MAX_TASKS),
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .item      (req),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .rsp       (rsp)
  );

  // A result is only shown once the controller is back at rest.
  a_rsp_when_idle: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !busy)
    else $error("result shown while an item is still in progress");

  // An admit finishes in the cycle it is accepted.
  a_admit_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (req.mode == rrts_pkg::MODE_ADMIT)) |=> rsp_valid)
    else $error("admit did not produce its result one cycle later");

  // Every tick that leaves the idle state ends with a result.
  a_tick_ends_with_rsp: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> rsp_valid)
    else $error("tick ended without a result");

  // A dropped admit reports nothing about scheduling.
  a_error_alone: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.admit_error) |-> (!rsp.elected_valid && !rsp.finished_valid))
    else $error("admit error reported together with tick fields");

endmodule

// ----- design/rrts_ctrl.sv -----
// ============================================================================
// rrts_ctrl: scheduler controller
// Sequences admit and tick items through the datapath, one item at a time.
// ============================================================================
module rrts_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  mode,
  input  rrts_pkg::ctl_status_t status,
  output rrts_pkg::ctl_cmd_t    cmd,
  output logic                  busy,
  output logic                  rsp_valid
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TRD   = 3'd1;
  localparam logic [2:0] S_EXAM  = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_QRD   = 3'd4;
  localparam logic [2:0] S_ELECT = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       electing;
  logic       electing_next;

  always_comb begin
    cmd           = '0;
    state_next    = state;
    electing_next = electing;
    case (state)
      S_IDLE: begin
        electing_next = 1'b0;
        if (start) begin
          if (mode == rrts_pkg::MODE_ADMIT) begin
            cmd.admit = 1'b1;
            cmd.done  = 1'b1;
          end else begin
            cmd.tick_clear = 1'b1;
            if (status.count_zero) begin
              cmd.tick_adv = 1'b1;
              cmd.done     = 1'b1;
            end else begin
              state_next = S_TRD;
            end
          end
        end
      end
      S_TRD: begin
        cmd.task_read = 1'b1;
        state_next    = electing ? S_ELECT : S_EXAM;
      end
      S_EXAM: begin
        if (status.finish_due) begin
          cmd.finish = 1'b1;
          state_next = S_WAIT;
        end else if (status.quantum_spent) begin
          cmd.rotate = 1'b1;
          state_next = S_QRD;
        end else begin
          cmd.elect    = 1'b1;
          cmd.tick_adv = 1'b1;
          cmd.done     = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_WAIT: begin
        cmd.wait_calc = 1'b1;
        if (status.count_zero) begin
          cmd.tick_adv = 1'b1;
          cmd.done     = 1'b1;
          state_next   = S_IDLE;
        end else begin
          state_next = S_QRD;
        end
      end
      S_QRD: begin
        // The queue read at the new head lands at the end of this cycle.
        electing_next = 1'b1;
        state_next    = S_TRD;
      end
      S_ELECT: begin
        cmd.elect    = 1'b1;
        cmd.tick_adv = 1'b1;
        cmd.done     = 1'b1;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      electing  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      electing  <= electing_next;
      rsp_valid <= cmd.done;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

// ----- design/rrts_datapath.sv -----
// ============================================================================
// rrts_datapath: scheduler datapath
// Run queue ring buffer, per-task stores, counters and the result register.
// ============================================================================
module rrts_datapath #(
  parameter int MAX_TASKS = rrts_pkg::MAX_TASKS_DEF,
  parameter int TIME_BITS = rrts_pkg::TIME_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  rrts_pkg::in_t                    item,
  input  logic                             cfg_valid,
  input  logic [rrts_pkg::QUANT_W-1:0]     cfg_data,
  input  rrts_pkg::ctl_cmd_t               cmd,
  output rrts_pkg::ctl_status_t            status,
  output rrts_pkg::out_t                   rsp
);

  localparam int ID_SPAN    = 2 ** rrts_pkg::ID_W;
  localparam int TASK_SLOTS = (MAX_TASKS < ID_SPAN) ? MAX_TASKS : ID_SPAN;
  localparam int TID_W      = $clog2(TASK_SLOTS);
  localparam int QI_W       = $clog2(MAX_TASKS);
  localparam int CNT_W      = $clog2(MAX_TASKS + 1);
  localparam int EXEC_W     = rrts_pkg::EXEC_W;
  localparam int QUANT_W    = rrts_pkg::QUANT_W;
  localparam int WIDE_W     = (TIME_BITS > EXEC_W) ? TIME_BITS : EXEC_W;

  // Configuration and counters.
  logic [QUANT_W-1:0]   quantum;
  logic [TIME_BITS-1:0] tick_count;
  logic [QI_W-1:0]      head;
  logic [CNT_W-1:0]     count;
  logic [TASK_SLOTS-1:0] present;

  // Run queue memory and its registered read.
  logic [TID_W-1:0] run_queue [MAX_TASKS];
  logic [TID_W-1:0] q_rdata;

  // Per-task stores and their registered reads.
  logic [EXEC_W-1:0]    mem_exec  [TASK_SLOTS];
  logic [EXEC_W-1:0]    mem_comp  [TASK_SLOTS];
  logic [QUANT_W-1:0]   mem_qleft [TASK_SLOTS];
  logic [TIME_BITS-1:0] mem_arr   [TASK_SLOTS];
  logic [EXEC_W-1:0]    rd_exec;
  logic [EXEC_W-1:0]    rd_comp;
  logic [QUANT_W-1:0]   rd_qleft;
  logic [TIME_BITS-1:0] rd_arr;
  logic [TID_W-1:0]     cur_id;

  logic [TIME_BITS-1:0] resp_reg;

  // Queue position arithmetic.
  logic [CNT_W:0]    tail_sum;
  logic [QI_W-1:0]   tail_slot;
  logic [QI_W-1:0]   head_inc;
  logic              full;

  // Admit checks.
  logic [TID_W-1:0]  id_t;
  logic              id_in_range;
  logic              admit_ok;
  logic              admit_go;
  rrts_pkg::out_t    admit_rsp;

  // Store write port.
  logic [TID_W-1:0]   waddr;
  logic [EXEC_W-1:0]  wexec;
  logic [QUANT_W-1:0] wqleft;
  logic               we_exec;
  logic               we_qleft;
  logic               q_we;
  logic [TID_W-1:0]   q_wdata;

  logic [EXEC_W-1:0]  exec_inc;
  logic [QUANT_W-1:0] qleft_dec;
  logic [WIDE_W-1:0]  resp_wide;
  logic [WIDE_W-1:0]  comp_wide;
  logic [WIDE_W-1:0]  wait_wide;

  assign tail_sum  = (CNT_W + 1)'(head) + (CNT_W + 1)'(count);
  assign tail_slot = (tail_sum >= (CNT_W + 1)'(MAX_TASKS))
                     ? QI_W'(tail_sum - (CNT_W + 1)'(MAX_TASKS))
                     : QI_W'(tail_sum);
  assign head_inc  = (head == QI_W'(MAX_TASKS - 1)) ? '0 : head + 1'b1;
  assign full      = (count == CNT_W'(MAX_TASKS));

  assign id_t        = item.task_id[TID_W-1:0];
  assign id_in_range = (32'(item.task_id) < 32'(MAX_TASKS));
  assign admit_ok    = id_in_range && !full && !present[id_t];
  assign admit_go    = cmd.admit && admit_ok;

  // An admit result carries only the error flag.
  always_comb begin
    admit_rsp             = '0;
    admit_rsp.admit_error = !admit_ok;
  end

  assign exec_inc  = (rd_exec == '1) ? rd_exec : rd_exec + 1'b1;
  assign qleft_dec = (rd_qleft == '0) ? rd_qleft : rd_qleft - 1'b1;

  assign waddr    = cmd.admit ? id_t : cur_id;
  assign wexec    = cmd.admit ? '0 : exec_inc;
  assign wqleft   = cmd.elect ? qleft_dec : quantum;
  assign we_exec  = admit_go || cmd.elect;
  assign we_qleft = admit_go || cmd.rotate || cmd.elect;
  assign q_we     = admit_go || cmd.rotate;
  assign q_wdata  = cmd.admit ? id_t : cur_id;

  // Response time wraps at the time width; waiting time never goes negative.
  assign resp_wide = WIDE_W'(resp_reg);
  assign comp_wide = WIDE_W'(rd_comp);
  assign wait_wide = (resp_wide >= comp_wide) ? resp_wide - comp_wide : '0;

  assign status.count_zero    = (count == '0);
  assign status.finish_due    = (rd_exec >= rd_comp);
  assign status.quantum_spent = (rd_qleft == '0);

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      quantum    <= rrts_pkg::QUANTUM_RESET;
      tick_count <= '0;
      head       <= '0;
      count      <= '0;
      present    <= '0;
    end else begin
      if (cfg_valid) begin
        quantum <= cfg_data;
      end
      if (cmd.tick_adv && (tick_count != '1)) begin
        tick_count <= tick_count + 1'b1;
      end
      if (admit_go) begin
        count         <= count + 1'b1;
        present[id_t] <= 1'b1;
      end
      if (cmd.finish) begin
        head            <= head_inc;
        count           <= count - 1'b1;
        present[cur_id] <= 1'b0;
      end
      if (cmd.rotate) begin
        head <= head_inc;
      end
    end
  end

  // Run queue.
  always_ff @(posedge clk) begin
    if (q_we) begin
      run_queue[tail_slot] <= q_wdata;
    end
    q_rdata <= run_queue[head];
  end

  // Per-task stores.
  always_ff @(posedge clk) begin
    if (we_exec) begin
      mem_exec[waddr] <= wexec;
    end
    if (admit_go) begin
      mem_comp[waddr] <= item.compute_time;
      mem_arr[waddr]  <= tick_count;
    end
    if (we_qleft) begin
      mem_qleft[waddr] <= wqleft;
    end
    if (cmd.task_read) begin
      rd_exec  <= mem_exec[q_rdata];
      rd_comp  <= mem_comp[q_rdata];
      rd_qleft <= mem_qleft[q_rdata];
      rd_arr   <= mem_arr[q_rdata];
      cur_id   <= q_rdata;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.admit) begin
      rsp <= admit_rsp;
    end
    if (cmd.tick_clear) begin
      rsp <= '0;
    end
    if (cmd.finish) begin
      resp_reg           <= tick_count - rd_arr;
      rsp.finished_valid <= 1'b1;
      rsp.finished_task  <= rrts_pkg::ID_W'(cur_id);
    end
    if (cmd.wait_calc) begin
      rsp.response_time <= resp_wide[rrts_pkg::OUT_T_W-1:0];
      rsp.waiting_time  <= wait_wide[rrts_pkg::OUT_T_W-1:0];
    end
    if (cmd.elect) begin
      rsp.elected_valid <= 1'b1;
      rsp.elected_task  <= rrts_pkg::ID_W'(cur_id);
    end
  end

endmodule

// ----- tb/sv/round_robin_task_scheduler_unit_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// round_robin_task_scheduler_unit_tb: self-checking bench for the scheduler
// Drives admit and tick items through the start/busy port and predicts each
// result with a behavioral scheduler kept inside the bench. Every result is
// compared field by field. The quantum register is swept over several values.
// ============================================================================
module round_robin_task_scheduler_unit_tb;

  localparam int NUM_TASKS = 16;
  localparam logic [15:0] TIME_LIMIT = 16'hFFFF;

  // Clock, reset and the ports of the block.
  logic                         clk;
  logic                         rst;
  logic                         start;
  logic                         busy;
  rrts_pkg::in_t                req;
  logic                         rsp_valid;
  rrts_pkg::out_t               rsp;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [rrts_pkg::QUANT_W-1:0] cfg_data;

  round_robin_task_scheduler_unit dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the scheduler state. It is advanced once per accepted
  // item, so it always describes the block as of the last accepted item.
  logic [rrts_pkg::ID_W-1:0]    run_ring   [NUM_TASKS];
  logic [rrts_pkg::ID_W-1:0]    run_head;
  int                           run_count;
  bit                           task_live  [NUM_TASKS];
  logic [rrts_pkg::EXEC_W-1:0]  exec_ticks [NUM_TASKS];
  logic [rrts_pkg::EXEC_W-1:0]  work_len   [NUM_TASKS];
  logic [rrts_pkg::QUANT_W-1:0] slice_left [NUM_TASKS];
  logic [15:0]                  arrived    [NUM_TASKS];
  logic [15:0]                  tick_now;
  logic [rrts_pkg::QUANT_W-1:0] quantum_now;

  // Results predicted for accepted items and not yet seen on the outputs.
  rrts_pkg::out_t pending_results[$];
  int   mismatch_count;
  // Largest idle gap in cycles that the sender draws before an item.
  int   item_gap_max;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one item to the shadow scheduler and returns the result that the
  // block must produce for it.
  function automatic rrts_pkg::out_t schedule_step(rrts_pkg::in_t it);
    rrts_pkg::out_t r;
    logic [3:0]  h;
    logic [3:0]  e;
    logic [3:0]  slot;
    logic [15:0] resp;
    r = '0;
    if (it.mode == rrts_pkg::MODE_ADMIT) begin
      // A full queue or an id that is already queued drops the admit.
      if (run_count >= NUM_TASKS || task_live[it.task_id]) begin
        r.admit_error = 1'b1;
      end else begin
        slot = run_head + run_count[3:0];
        run_ring[slot] = it.task_id;
        run_count++;
        task_live[it.task_id]  = 1'b1;
        exec_ticks[it.task_id] = '0;
        work_len[it.task_id]   = it.compute_time;
        slice_left[it.task_id] = quantum_now;
        arrived[it.task_id]    = tick_now;
      end
    end else begin
      if (run_count > 0) begin
        h = run_ring[run_head];
        if (exec_ticks[h] >= work_len[h]) begin
          // The head has done all its work: retire it. A response shorter
          // than the compute length reports a waiting time of zero.
          resp = tick_now - arrived[h];
          r.finished_valid = 1'b1;
          r.finished_task  = h;
          r.response_time  = resp;
          r.waiting_time   = (resp >= work_len[h]) ? resp - work_len[h] : '0;
          task_live[h] = 1'b0;
          run_head++;
          run_count--;
        end else if (slice_left[h] == 0) begin
          // Quantum used up: the head goes to the tail with a fresh quantum.
          run_head++;
          slot = run_head + run_count[3:0] - 4'd1;
          run_ring[slot] = h;
          slice_left[h]  = quantum_now;
        end
        if (run_count > 0) begin
          e = run_ring[run_head];
          if (exec_ticks[e] != 16'hFFFF) exec_ticks[e]++;
          if (slice_left[e] != 0) slice_left[e]--;
          r.elected_valid = 1'b1;
          r.elected_task  = e;
        end
      end
      if (tick_now != TIME_LIMIT) tick_now++;
    end
    return r;
  endfunction

  // Sends one item after a random idle gap, if any, and records its expected
  // result at the edge where the block takes it. start is left high so that a
  // following item with no gap goes out back to back.
  task automatic send_item(input logic mode, input logic [rrts_pkg::ID_W-1:0] id,
                           input logic [rrts_pkg::EXEC_W-1:0] work);
    int  gap;
    rrts_pkg::in_t it;
    gap = 0;
    if (item_gap_max > 0 && $urandom_range(0, 1) == 1) gap = $urandom_range(1, item_gap_max);
    it.mode         = mode;
    it.task_id      = id;
    it.compute_time = work;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= it;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(schedule_step(it));
  endtask

  task automatic send_tick();
    send_item(rrts_pkg::MODE_TICK, 4'($urandom_range(0, 15)),
              16'($urandom_range(0, 65535)));
  endtask

  // Writes the quantum register once the block has delivered every pending
  // result and has had time to settle back to idle.
  task automatic write_quantum(input logic [rrts_pkg::QUANT_W-1:0] q);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= q;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid   <= 1'b0;
    quantum_now = q;
  endtask

  // Every result is compared with the oldest prediction.
  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    rrts_pkg::out_t exp_r;
    if (!rst) begin
      if ($isunknown(rsp_valid)) begin
        $error("rsp_valid: expected a known value, got %b", rsp_valid);
        mismatch_count++;
      end else if (rsp_valid) begin
        if (pending_results.size() == 0) begin
          $error("result: expected none pending, got one");
          mismatch_count++;
        end else begin
          exp_r = pending_results.pop_front();
          check_field("elected_valid", 16'(exp_r.elected_valid), 16'(rsp.elected_valid));
          check_field("elected_task", 16'(exp_r.elected_task), 16'(rsp.elected_task));
          check_field("finished_valid", 16'(exp_r.finished_valid),
                      16'(rsp.finished_valid));
          check_field("finished_task", 16'(exp_r.finished_task), 16'(rsp.finished_task));
          check_field("response_time", exp_r.response_time, rsp.response_time);
          check_field("waiting_time", exp_r.waiting_time, rsp.waiting_time);
          check_field("admit_error", 16'(exp_r.admit_error), 16'(rsp.admit_error));
        end
      end
    end
  end

  // A tick on an empty queue elects nothing but still moves time forward.
  task automatic test_empty_tick();
    send_tick();
  endtask

  // A few tasks under the reset quantum: one needing no work at all, one
  // rotating, and a second admit of an id that is still queued.
  task automatic test_basic_schedule();
    send_item(rrts_pkg::MODE_ADMIT, 4'd0, 16'd3);
    send_item(rrts_pkg::MODE_ADMIT, 4'd1, 16'd1);
    send_item(rrts_pkg::MODE_ADMIT, 4'd2, 16'd0);
    send_item(rrts_pkg::MODE_ADMIT, 4'd1, 16'hFFFF);
    repeat (4) send_tick();
  endtask

  // Fills the run queue with every id, then admits into the full queue.
  task automatic test_queue_full();
    int id;
    for (id = 0; id < NUM_TASKS; id++) begin
      if (!task_live[id]) send_item(rrts_pkg::MODE_ADMIT, id[3:0], 16'd1 + id[1:0]);
    end
    send_item(rrts_pkg::MODE_ADMIT, 4'd15, 16'hFFFF);
  endtask

  // One random phase under a given quantum. Admits are likelier while the
  // queue is short, mostly pick an id that is free and carry a short
  // compute length, so tasks keep finishing and rotating. Admits that will
  // be dropped carry arbitrary compute lengths.
  task automatic run_phase(input logic [rrts_pkg::QUANT_W-1:0] q, input int gap_max,
                           input int num_items);
    int n;
    int pct;
    int k;
    int id;
    logic [rrts_pkg::EXEC_W-1:0] work;
    write_quantum(q);
    item_gap_max = gap_max;
    for (n = 0; n < num_items; n++) begin
      pct = (run_count < 4) ? 50 : (run_count < 12) ? 20 : 10;
      if ($urandom_range(0, 99) < pct) begin
        id = $urandom_range(0, 15);
        if ($urandom_range(0, 9) != 0) begin
          for (k = 0; k < NUM_TASKS && task_live[id]; k++) id = (id + 1) % NUM_TASKS;
        end
        if (task_live[id] || run_count >= NUM_TASKS) work = 16'($urandom_range(0, 65535));
        else if ($urandom_range(0, 19) == 0) work = 16'($urandom_range(13, 100));
        else work = 16'($urandom_range(0, 12));
        send_item(rrts_pkg::MODE_ADMIT, id[3:0], work);
      end else begin
        send_tick();
      end
    end
  endtask

  // Quantum sweep: the smallest nonzero, the largest, zero (rotation on every
  // tick), and some values in between. One phase runs with no idle gaps.
  task automatic test_random_quanta();
    run_phase(8'd1, 16, 190);
    run_phase(8'd255, 16, 190);
    run_phase(8'd0, 16, 190);
    run_phase(8'd3, 0, 190);
    run_phase(8'($urandom_range(1, 255)), 16, 190);
    run_phase(8'd2, 8, 190);
  endtask

  // Ticks until the queue is empty again.
  task automatic test_drain();
    item_gap_max = 4;
    while (run_count > 0) send_tick();
    send_tick();
  endtask

  initial begin
    int guard;
    clk            = 1'b0;
    mismatch_count = 0;
    item_gap_max   = 16;
    rst       <= 1'b1;
    start     <= 1'b0;
    req       <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    run_head    = '0;
    run_count   = 0;
    tick_now    = '0;
    quantum_now = rrts_pkg::QUANTUM_RESET;
    for (int i = 0; i < NUM_TASKS; i++) begin
      run_ring[i]   = '0;
      task_live[i]  = 1'b0;
      exec_ticks[i] = '0;
      work_len[i]   = '0;
      slice_left[i] = '0;
      arrived[i]    = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_empty_tick();
    test_basic_schedule();
    test_queue_full();
    test_random_quanta();
    test_drain();

    // Let the last results come out, then wait on to catch any stray result.
    start <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: the slowest correct run stays far below this.
  initial begin
    #50ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/rrts_pkg.sv
design/rrts_ctrl.sv
design/rrts_datapath.sv
design/round_robin_task_scheduler_unit.sv
tb/sv/round_robin_task_scheduler_unit_tb.sv
